@@ src/pakf_pkg.sv @@
// ----------------------------------------------------------------------------
// pakf_pkg
// Shared types and constants for the particle age and keyframe update block.
// ----------------------------------------------------------------------------
package pakf_pkg;

    typedef enum logic
    {
        OP_INIT    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        CFG_LIFE_EXPECTANCY   = 3'd0,
        CFG_FRAMES_PER_SECOND = 3'd1,
        CFG_FRAME_RANGE       = 3'd2,
        CFG_SIZE_KEYS         = 3'd3,
        CFG_ALPHA_KEYS        = 3'd4,
        CFG_COLOR_START       = 3'd5,
        CFG_COLOR_MID         = 3'd6,
        CFG_COLOR_END         = 3'd7
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int KEY_W      = 16;
    localparam int MAT_W      = 17;

    // life expectancy code for endless looping
    localparam logic signed [16:0] LE_ENDLESS = -17'sd1;

    localparam logic [MAT_W-1:0] MAT_ONE  = 17'h10000;
    localparam logic [MAT_W-1:0] MAT_HALF = 17'h08000;

    typedef struct packed
    {
        op_t                operation;
        logic [31:0]        age;
        logic [31:0]        anim_span;
        logic signed [31:0] height;
        logic signed [31:0] rise_rate;
        logic [31:0]        time_step;
    } item_t;

    typedef struct packed
    {
        logic [31:0]        new_age;
        logic [31:0]        new_anim_span;
        logic signed [31:0] new_height;
        logic [7:0]         frame_index;
        logic [15:0]        particle_size;
        logic [15:0]        red_level;
        logic [15:0]        green_level;
        logic [15:0]        blue_level;
        logic [15:0]        opacity;
        logic               expired;
    } res_t;

    // per-item control and carried fields that ride along the divider
    typedef struct packed
    {
        op_t                op;
        logic               expired;
        logic               div_zero;
        logic [31:0]        age;
        logic [31:0]        span;
        logic signed [31:0] height;
    } sb_t;

endpackage

@@ src/pakf_if.sv @@
// ----------------------------------------------------------------------------
// pakf_if
// Valid/ready channels for particle records and update results.
// ----------------------------------------------------------------------------
interface pakf_item_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [31:0]        age;
    logic [31:0]        anim_span;
    logic signed [31:0] height;
    logic signed [31:0] rise_rate;
    logic [31:0]        time_step;

    modport source
    (
        output valid, operation, age, anim_span, height, rise_rate, time_step,
        input  ready
    );
    modport sink
    (
        input  valid, operation, age, anim_span, height, rise_rate, time_step,
        output ready
    );
endinterface

interface pakf_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        new_age;
    logic [31:0]        new_anim_span;
    logic signed [31:0] new_height;
    logic [7:0]         frame_index;
    logic [15:0]        particle_size;
    logic [15:0]        red_level;
    logic [15:0]        green_level;
    logic [15:0]        blue_level;
    logic [15:0]        opacity;
    logic               expired;

    modport source
    (
        output valid, new_age, new_anim_span, new_height, frame_index, particle_size,
               red_level, green_level, blue_level, opacity, expired,
        input  ready
    );
    modport sink
    (
        input  valid, new_age, new_anim_span, new_height, frame_index, particle_size,
               red_level, green_level, blue_level, opacity, expired,
        output ready
    );
endinterface

@@ src/particle_age_and_keyframe_update.sv @@
// ----------------------------------------------------------------------------
// particle_age_and_keyframe_update
// Advances particle records: age, height, frame, size, color and alpha.
// ----------------------------------------------------------------------------
// Takes one particle record per clock and returns one updated record per
// record, in order. The pipeline is three front stages, one stage per
// quotient bit in the divider that forms maturity (or the animation span in
// init mode), with NUM_W = max(33, 16 + TIME_FRAC_BITS) + 16 quotient bits,
// one stage that picks the maturity, three interpolation stages and the
// output register. The divider length sets the latency; throughput is one
// transaction per clock as long as results are taken.
// A two-entry output (register plus skid) lets the pipeline keep
// accepting while one result waits; ready drops only once both are full.
// Configuration must be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module particle_age_and_keyframe_update #(
    parameter int TIME_FRAC_BITS = 16,
    parameter int FRAME_BITS     = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pakf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pakf_pkg::CFG_DATA_W-1:0] cfg_data,
    pakf_item_if.sink                       item,
    pakf_result_if.source                   result
);
    import pakf_pkg::*;

    localparam int CW    = (16 + TIME_FRAC_BITS > 33) ? 16 + TIME_FRAC_BITS : 33;
    localparam int NUM_W = CW + 16;
    localparam int FB    = FRAME_BITS;
    localparam int FR_W  = 2 * FB;
    localparam int FP_W  = FB + 19;

    // configuration registers
    logic signed [16:0] le_reg;
    logic [7:0]         fps_reg;
    logic [15:0]        fr_reg;
    logic [47:0]        size_reg, alpha_reg, cs_reg, cm_reg, ce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg    <= LE_ENDLESS;
            fps_reg   <= '0;
            fr_reg    <= '0;
            size_reg  <= '0;
            alpha_reg <= '0;
            cs_reg    <= '0;
            cm_reg    <= '0;
            ce_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LIFE_EXPECTANCY:   le_reg    <= cfg_data[16:0];
                CFG_FRAMES_PER_SECOND: fps_reg   <= cfg_data[7:0];
                CFG_FRAME_RANGE:       fr_reg    <= cfg_data[15:0];
                CFG_SIZE_KEYS:         size_reg  <= cfg_data;
                CFG_ALPHA_KEYS:        alpha_reg <= cfg_data;
                CFG_COLOR_START:       cs_reg    <= cfg_data;
                CFG_COLOR_MID:         cm_reg    <= cfg_data;
                CFG_COLOR_END:         ce_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // global pipeline advance: held only while the skid entry is occupied
    logic en;
    logic skid_v_reg, skid_v_next;
    logic out_v_reg, out_v_next;
    res_t skid_reg, skid_next;
    res_t out_reg, out_next;

    assign en         = !skid_v_reg;
    assign item.ready = en;

    item_t in_item;
    always_comb
    begin
        in_item.operation = op_t'(item.operation);
        in_item.age       = item.age;
        in_item.anim_span = item.anim_span;
        in_item.height    = item.height;
        in_item.rise_rate = item.rise_rate;
        in_item.time_step = item.time_step;
    end

    // front end
    logic             fe_v;
    logic [NUM_W-1:0] fe_num;
    logic [CW-1:0]    fe_den;
    sb_t              fe_sb;

    pakf_front #(
        .TFB   (TIME_FRAC_BITS),
        .FB    (FB),
        .CW    (CW),
        .NUM_W (NUM_W)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_v              (item.valid),
        .in_item           (in_item),
        .life_expectancy   (le_reg),
        .frames_per_second (fps_reg),
        .frame_range       (fr_reg),
        .out_v             (fe_v),
        .num               (fe_num),
        .den               (fe_den),
        .sb                (fe_sb)
    );

    // divider: maturity in advance mode, animation span in init mode
    logic             dv_v;
    logic [NUM_W-1:0] dv_q;
    sb_t              dv_sb;

    pakf_div #(
        .NUM_W (NUM_W),
        .DEN_W (CW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (fe_v),
        .num    (fe_num),
        .den    (fe_den),
        .in_sb  (fe_sb),
        .out_v  (dv_v),
        .quo    (dv_q),
        .out_sb (dv_sb)
    );

    // stage D: maturity and final span
    logic             d_v_reg;
    logic [MAT_W-1:0] mat_reg, mat_next;
    sb_t              d_sb_reg, d_sb_next;

    always_comb
    begin
        d_sb_next = dv_sb;
        mat_next  = '0;
        if (dv_sb.op == OP_ADVANCE)
        begin
            if (!dv_sb.div_zero)
                mat_next = (dv_q > NUM_W'(MAT_ONE)) ? MAT_ONE : dv_q[MAT_W-1:0];
        end
        else if (!dv_sb.div_zero)
        begin
            d_sb_next.span = (|dv_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : dv_q[31:0];
        end
    end

    // frame: first + ceil(mat * (last - first) / 2^16)
    logic [FR_W-1:0]      fr_ext;
    logic [FB-1:0]        first, last;
    logic signed [FB:0]   fdiff;
    logic signed [FP_W-1:0] fp_reg, fp_next, fsum, fceil;
    logic [FB-1:0]        f2_reg, f2_next, f3_reg;

    always_comb
    begin
        fr_ext  = FR_W'(fr_reg);
        first   = fr_ext[FB-1:0];
        last    = fr_ext[FR_W-1:FB];
        fdiff   = $signed({1'b0, last}) - $signed({1'b0, first});
        fp_next = $signed({1'b0, mat_reg}) * fdiff;
        fsum    = fp_reg + $signed(FP_W'(16'hFFFF));
        fceil   = fsum >>> 16;
        f2_next = FB'(fceil[FB-1:0] + first);
    end

    // interpolation stages: valid and carried fields
    logic l_v_reg  [3];
    sb_t  l_sb_reg [3];

    logic [KEY_W-1:0] size_l, red_l, green_l, blue_l, alpha_l;

    pakf_lerp u_size  (.clk(clk), .en(en), .mat(mat_reg), .key_s(size_reg[15:0]),
                       .key_m(size_reg[31:16]), .key_e(size_reg[47:32]), .res(size_l));
    pakf_lerp u_red   (.clk(clk), .en(en), .mat(mat_reg), .key_s(cs_reg[15:0]),
                       .key_m(cm_reg[15:0]), .key_e(ce_reg[15:0]), .res(red_l));
    pakf_lerp u_green (.clk(clk), .en(en), .mat(mat_reg), .key_s(cs_reg[31:16]),
                       .key_m(cm_reg[31:16]), .key_e(ce_reg[31:16]), .res(green_l));
    pakf_lerp u_blue  (.clk(clk), .en(en), .mat(mat_reg), .key_s(cs_reg[47:32]),
                       .key_m(cm_reg[47:32]), .key_e(ce_reg[47:32]), .res(blue_l));
    pakf_lerp u_alpha (.clk(clk), .en(en), .mat(mat_reg), .key_s(alpha_reg[15:0]),
                       .key_m(alpha_reg[31:16]), .key_e(alpha_reg[47:32]), .res(alpha_l));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg    <= 1'b0;
            l_v_reg[0] <= 1'b0;
            l_v_reg[1] <= 1'b0;
            l_v_reg[2] <= 1'b0;
        end
        else if (en)
        begin
            d_v_reg    <= dv_v;
            l_v_reg[0] <= d_v_reg;
            l_v_reg[1] <= l_v_reg[0];
            l_v_reg[2] <= l_v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg     <= mat_next;
            d_sb_reg    <= d_sb_next;
            l_sb_reg[0] <= d_sb_reg;
            l_sb_reg[1] <= l_sb_reg[0];
            l_sb_reg[2] <= l_sb_reg[1];
            fp_reg      <= fp_next;
            f2_reg      <= f2_next;
            f3_reg      <= f2_reg;
        end
    end

    // result assembly
    res_t res_new;
    logic live;

    always_comb
    begin
        live                  = l_sb_reg[2].op == OP_ADVANCE && !l_sb_reg[2].expired;
        res_new.new_age       = l_sb_reg[2].age;
        res_new.new_anim_span = l_sb_reg[2].span;
        res_new.new_height    = l_sb_reg[2].height;
        res_new.expired       = l_sb_reg[2].expired;
        if (l_sb_reg[2].op == OP_INIT)
            res_new.frame_index = 8'(first);
        else if (live)
            res_new.frame_index = 8'(f3_reg);
        else
            res_new.frame_index = '0;
        res_new.particle_size = live ? size_l  : '0;
        res_new.red_level     = live ? red_l   : '0;
        res_new.green_level   = live ? green_l : '0;
        res_new.blue_level    = live ? blue_l  : '0;
        res_new.opacity       = live ? alpha_l : '0;
    end

    // output register and skid entry
    logic arrive, take;

    always_comb
    begin
        arrive      = en && l_v_reg[2];
        take        = out_v_reg && result.ready;
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (skid_v_reg)
        begin
            if (take)
            begin
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_v_reg || take)
            begin
                out_next   = res_new;
                out_v_next = 1'b1;
            end
            else
            begin
                skid_next   = res_new;
                skid_v_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid         = out_v_reg;
    assign result.new_age       = out_reg.new_age;
    assign result.new_anim_span = out_reg.new_anim_span;
    assign result.new_height    = out_reg.new_height;
    assign result.frame_index   = out_reg.frame_index;
    assign result.particle_size = out_reg.particle_size;
    assign result.red_level     = out_reg.red_level;
    assign result.green_level   = out_reg.green_level;
    assign result.blue_level    = out_reg.blue_level;
    assign result.opacity       = out_reg.opacity;
    assign result.expired       = out_reg.expired;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry holds a result while output register is empty");

    a_expired_only_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_v && dv_sb.expired) |-> (dv_sb.op == OP_ADVANCE))
        else $error("init transaction flagged as expired");

    a_expired_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.expired) |-> (result.frame_index == 8'd0 &&
        result.particle_size == 16'd0 && result.opacity == 16'd0 &&
        result.red_level == 16'd0))
        else $error("expired result carries animation values");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !result.ready && l_v_reg[2]))
        else $error("skid entry loaded without a stalled output");
`endif

endmodule

@@ src/pakf_front.sv @@
// ----------------------------------------------------------------------------
// pakf_front
// Input register, age clamp / wrap, velocity product, height update and
// divider operand select. Three register stages.
// ----------------------------------------------------------------------------
module pakf_front #(
    parameter int TFB   = 16,
    parameter int FB    = 8,
    parameter int CW    = 33,
    parameter int NUM_W = 49
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_v,
    input  pakf_pkg::item_t           in_item,
    input  logic signed [16:0]        life_expectancy,
    input  logic [7:0]                frames_per_second,
    input  logic [15:0]               frame_range,
    output logic                      out_v,
    output logic [NUM_W-1:0]          num,
    output logic [CW-1:0]             den,
    output pakf_pkg::sb_t             sb
);
    import pakf_pkg::*;

    localparam int FR_W = 2 * FB;

    // stage A: input register
    logic  a_v_reg;
    item_t a_item_reg;

    // stage B
    logic                b_v_reg;
    item_t               b_item_reg;
    logic                b_exp_reg,  b_exp_next;
    logic [31:0]         b_age_reg,  b_age_next;
    logic [NUM_W-1:0]    b_num_reg,  b_num_next;
    logic [CW-1:0]       b_den_reg,  b_den_next;
    logic signed [64:0]  b_prod_reg, b_prod_next;

    // stage C
    logic             c_v_reg;
    logic [NUM_W-1:0] c_num_reg;
    logic [CW-1:0]    c_den_reg;
    sb_t              c_sb_reg, c_sb_next;

    logic              limited;
    logic [CW-1:0]     limit_c, sum_c, span_c, age_c;
    logic              exp_c;
    logic [FR_W-1:0]   fr_ext;
    logic [FB-1:0]     first, last;
    logic signed [FB+1:0] cnt_s;
    logic [FB:0]       cnt;
    logic signed [64:0] step_dz;
    logic signed [65:0] hsum;
    logic signed [31:0] h_new;

    always_comb
    begin
        limited = life_expectancy != LE_ENDLESS;
        limit_c = CW'({life_expectancy[15:0], {TFB{1'b0}}});
        sum_c   = CW'({1'b0, a_item_reg.age} + {1'b0, a_item_reg.time_step});
        span_c  = CW'(a_item_reg.anim_span);
        if (limited)
        begin
            if (life_expectancy[16])
            begin
                // negative limit saturates the age to zero
                age_c = '0;
                exp_c = 1'b1;
            end
            else if (sum_c >= limit_c)
            begin
                age_c = limit_c;
                exp_c = 1'b1;
            end
            else
            begin
                age_c = sum_c;
                exp_c = 1'b0;
            end
        end
        else
        begin
            exp_c = 1'b0;
            if (a_item_reg.age == a_item_reg.anim_span)
                age_c = '0;
            else if (sum_c > span_c)
                age_c = span_c;
            else
                age_c = sum_c;
        end

        fr_ext = FR_W'(frame_range);
        first  = fr_ext[FB-1:0];
        last   = fr_ext[FR_W-1:FB];
        cnt_s  = $signed({2'b00, last}) - $signed({2'b00, first}) + (FB+2)'(1);
        cnt    = cnt_s[FB+1] ? '0 : cnt_s[FB:0];

        b_prod_next = a_item_reg.rise_rate * $signed({1'b0, a_item_reg.time_step});
        if (a_item_reg.operation == OP_ADVANCE)
        begin
            b_exp_next = exp_c;
            b_age_next = (|age_c[CW-1:32]) ? 32'hFFFF_FFFF : age_c[31:0];
            b_num_next = {age_c, 16'h0000};
            b_den_next = limited ? limit_c : span_c;
        end
        else
        begin
            b_exp_next = 1'b0;
            b_age_next = a_item_reg.age;
            b_num_next = NUM_W'({cnt, {TFB{1'b0}}});
            b_den_next = CW'(frames_per_second);
        end
    end

    // stage C: height update, floor of velocity times step
    always_comb
    begin
        step_dz = b_prod_reg >>> TFB;
        hsum    = {{34{b_item_reg.height[31]}}, b_item_reg.height} + {step_dz[64], step_dz};
        if (hsum[65:31] != {35{hsum[65]}})
            h_new = hsum[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            h_new = hsum[31:0];

        c_sb_next.op       = b_item_reg.operation;
        c_sb_next.expired  = b_exp_reg;
        c_sb_next.div_zero = b_den_reg == '0;
        c_sb_next.age      = b_age_reg;
        c_sb_next.span     = b_item_reg.anim_span;
        c_sb_next.height   = (b_item_reg.operation == OP_ADVANCE && !b_exp_reg)
                             ? h_new : b_item_reg.height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_v;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= in_item;
            b_item_reg <= a_item_reg;
            b_exp_reg  <= b_exp_next;
            b_age_reg  <= b_age_next;
            b_num_reg  <= b_num_next;
            b_den_reg  <= b_den_next;
            b_prod_reg <= b_prod_next;
            c_num_reg  <= b_num_reg;
            c_den_reg  <= b_den_reg;
            c_sb_reg   <= c_sb_next;
        end
    end

    assign out_v = c_v_reg;
    assign num   = c_num_reg;
    assign den   = c_den_reg;
    assign sb    = c_sb_reg;

endmodule

@@ src/pakf_div.sv @@
// ----------------------------------------------------------------------------
// pakf_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pakf_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_v,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  pakf_pkg::sb_t     in_sb,
    output logic              out_v,
    output logic [NUM_W-1:0]  quo,
    output pakf_pkg::sb_t     out_sb
);
    import pakf_pkg::*;

    logic             v_reg  [NUM_W];
    logic [NUM_W-1:0] n_reg  [NUM_W];
    logic [DEN_W-1:0] r_reg  [NUM_W];
    logic [DEN_W-1:0] d_reg  [NUM_W];
    sb_t              sb_reg [NUM_W];

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_stage
            logic             v_in;
            logic [NUM_W-1:0] n_in, n_next;
            logic [DEN_W-1:0] r_in, d_in, r_next;
            sb_t              sb_in;
            logic [DEN_W:0]   trial;
            logic             ge;

            if (i == 0)
            begin : g_head
                assign v_in  = in_v;
                assign n_in  = num;
                assign r_in  = '0;
                assign d_in  = den;
                assign sb_in = in_sb;
            end
            else
            begin : g_body
                assign v_in  = v_reg[i-1];
                assign n_in  = n_reg[i-1];
                assign r_in  = r_reg[i-1];
                assign d_in  = d_reg[i-1];
                assign sb_in = sb_reg[i-1];
            end

            // dividend bits shift out the top, quotient bits shift in below
            assign trial  = {r_in, n_in[NUM_W-1]};
            assign ge     = trial >= {1'b0, d_in};
            assign r_next = ge ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
            assign n_next = {n_in[NUM_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i]  <= n_next;
                    r_reg[i]  <= r_next;
                    d_reg[i]  <= d_in;
                    sb_reg[i] <= sb_in;
                end
            end
        end
    endgenerate

    assign out_v  = v_reg[NUM_W-1];
    assign quo    = n_reg[NUM_W-1];
    assign out_sb = sb_reg[NUM_W-1];

endmodule

@@ src/pakf_lerp.sv @@
// ----------------------------------------------------------------------------
// pakf_lerp
// Three-key piecewise-linear interpolation, round half up. Three stages.
// ----------------------------------------------------------------------------
module pakf_lerp (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pakf_pkg::MAT_W-1:0]  mat,
    input  logic [pakf_pkg::KEY_W-1:0]  key_s,
    input  logic [pakf_pkg::KEY_W-1:0]  key_m,
    input  logic [pakf_pkg::KEY_W-1:0]  key_e,
    output logic [pakf_pkg::KEY_W-1:0]  res
);
    import pakf_pkg::*;

    logic [MAT_W-1:0]     tt_reg, tt_next, om_reg, om_next;
    logic [KEY_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [MAT_W+KEY_W-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [KEY_W-1:0]     res_reg, res_next;
    logic [MAT_W+KEY_W:0] acc;

    always_comb
    begin
        if (mat < MAT_HALF)
        begin
            tt_next = MAT_W'({mat[MAT_W-2:0], 1'b0});
            a_next  = key_s;
            b_next  = key_m;
        end
        else
        begin
            tt_next = MAT_W'({mat - MAT_HALF, 1'b0});
            a_next  = key_m;
            b_next  = key_e;
        end
        om_next  = MAT_ONE - tt_next;
        p1_next  = om_reg * a_reg;
        p2_next  = tt_reg * b_reg;
        acc      = {1'b0, p1_reg} + {1'b0, p2_reg} + (MAT_W+KEY_W+1)'(MAT_HALF);
        res_next = acc[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg  <= tt_next;
            om_reg  <= om_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for particle_age_and_keyframe_update: a local
// predictor computes each updated particle record, results are compared in
// order, with random idle gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import pakf_pkg::*;

    localparam int DRAIN_CYCLES = 80;    // a bit over the pipeline depth
    localparam int WATCHDOG_MAX = 4000;  // cycles with no transaction at all

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pakf_item_if   item_ch();
    pakf_result_if res_ch();

    particle_age_and_keyframe_update DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch.sink),
        .result    (res_ch.source)
    );

    // mirror of the block's registers
    logic signed [16:0] life_cfg;
    logic [7:0]         fps_cfg;
    logic [15:0]        frames_cfg;
    logic [47:0]        size_cfg;
    logic [47:0]        alpha_cfg;
    logic [47:0]        color_s_cfg;
    logic [47:0]        color_m_cfg;
    logic [47:0]        color_e_cfg;

    res_t pending_records[$];
    bit   failed = 1'b0;
    bit   no_idle;        // when set, the sender never pauses
    int   quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // three-key piecewise-linear blend, rounded half up
    function automatic logic [15:0] key_blend(longint unsigned ks, longint unsigned km,
                                              longint unsigned ke, longint unsigned mat);
        longint unsigned tt;
        longint unsigned a;
        longint unsigned b;
        if (mat < 32768)
        begin
            tt = 2 * mat;
            a  = ks;
            b  = km;
        end
        else
        begin
            tt = 2 * (mat - 32768);
            a  = km;
            b  = ke;
        end
        if (tt > 65536)
            tt = 65536;
        return 16'(((65536 - tt) * a + tt * b + 32768) >> 16);
    endfunction

    function automatic res_t predict_record(item_t it);
        res_t   r;
        longint a;
        longint s;
        longint h;
        longint rt;
        longint dt;
        longint lim;
        longint first;
        longint last;
        longint mat;
        longint d;
        longint v;
        longint c;
        longint fr;
        longint cnt;
        bit     limited;
        r     = '0;
        a     = longint'(it.age);
        s     = longint'(it.anim_span);
        h     = longint'(it.height);
        rt    = longint'(it.rise_rate);
        dt    = longint'(it.time_step);
        first = longint'(frames_cfg[7:0]);
        last  = longint'(frames_cfg[15:8]);
        fr    = 0;
        lim   = 0;
        if (it.operation == OP_INIT)
        begin
            if (fps_cfg != 0)
            begin
                cnt = last - first + 1;
                if (cnt < 0)
                    cnt = 0;
                s = (cnt << 16) / longint'(fps_cfg);
            end
            fr = first;
        end
        else
        begin
            limited = (life_cfg != LE_ENDLESS);
            if (limited)
            begin
                // negative limits other than endless clamp the age below zero
                lim = (life_cfg < 0) ? longint'(life_cfg) : (longint'(life_cfg) << 16);
                a = a + dt;
                if (a > lim)
                    a = lim;
            end
            else if (a == s)
                a = 0;  // looping particle wraps once it sits on the span
            else
            begin
                a = a + dt;
                if (a > s)
                    a = s;
            end
            if (limited && a >= lim)
                r.expired = 1'b1;
            else
            begin
                h = h + ((rt * dt) >>> 16);
                if (h > 64'sd2147483647)
                    h = 64'sd2147483647;
                if (h < -64'sd2147483648)
                    h = -64'sd2147483648;
                mat = 0;
                if (limited)
                begin
                    if (lim > 0 && a > 0)
                        mat = (a << 16) / lim;
                end
                else if (s > 0 && a > 0)
                    mat = (a << 16) / s;
                if (mat > 65536)
                    mat = 65536;
                d = last - first;
                v = mat * d;
                // ceiling for either sign
                c = (v >= 0) ? ((v + 65535) >> 16) : -((-v) >> 16);
                fr = first + c;
                r.particle_size = key_blend(size_cfg[15:0], size_cfg[31:16],
                                            size_cfg[47:32], mat);
                r.red_level     = key_blend(color_s_cfg[15:0], color_m_cfg[15:0],
                                            color_e_cfg[15:0], mat);
                r.green_level   = key_blend(color_s_cfg[31:16], color_m_cfg[31:16],
                                            color_e_cfg[31:16], mat);
                r.blue_level    = key_blend(color_s_cfg[47:32], color_m_cfg[47:32],
                                            color_e_cfg[47:32], mat);
                r.opacity       = key_blend(alpha_cfg[15:0], alpha_cfg[31:16],
                                            alpha_cfg[47:32], mat);
            end
        end
        if (fr < 0)
            fr = 0;
        if (fr > 255)
            fr = 255;
        if (a < 0)
            a = 0;
        if (a > 64'hFFFFFFFF)
            a = 64'hFFFFFFFF;
        r.new_age       = a[31:0];
        r.new_anim_span = s[31:0];
        r.new_height    = h[31:0];
        r.frame_index   = fr[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // mostly back-to-back or short pauses, now and then a long one
    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge, returns at the edge the transaction is taken
    task automatic send_record(op_t op, logic [31:0] age, logic [31:0] span,
                               logic [31:0] height, logic [31:0] rate, logic [31:0] dt);
        item_t it;
        int    gap;
        bit    taken;
        gap = no_idle ? 0 : gap_cycles();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.operation = op;
        it.age       = age;
        it.anim_span = span;
        it.height    = height;
        it.rise_rate = rate;
        it.time_step = dt;
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.age       <= age;
        item_ch.anim_span <= span;
        item_ch.height    <= height;
        item_ch.rise_rate <= rate;
        item_ch.time_step <= dt;
        do
        begin
            @(negedge clk);
            taken = item_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        pending_records.push_back(predict_record(it));
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [47:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            CFG_LIFE_EXPECTANCY:   life_cfg    = d[16:0];
            CFG_FRAMES_PER_SECOND: fps_cfg     = d[7:0];
            CFG_FRAME_RANGE:       frames_cfg  = d[15:0];
            CFG_SIZE_KEYS:         size_cfg    = d;
            CFG_ALPHA_KEYS:        alpha_cfg   = d;
            CFG_COLOR_START:       color_s_cfg = d;
            CFG_COLOR_MID:         color_m_cfg = d;
            default:               color_e_cfg = d;
        endcase
    endtask

    task automatic program_regs(logic [16:0] le, logic [7:0] fps, logic [15:0] fr,
                                logic [47:0] sk, logic [47:0] ak, logic [47:0] cs,
                                logic [47:0] cm, logic [47:0] ce);
        wait_idle();
        write_reg(CFG_LIFE_EXPECTANCY, 48'(le));
        write_reg(CFG_FRAMES_PER_SECOND, 48'(fps));
        write_reg(CFG_FRAME_RANGE, 48'(fr));
        write_reg(CFG_SIZE_KEYS, sk);
        write_reg(CFG_ALPHA_KEYS, ak);
        write_reg(CFG_COLOR_START, cs);
        write_reg(CFG_COLOR_MID, cm);
        write_reg(CFG_COLOR_END, ce);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // endless looping: wrap on the span, clamp, zero span, init without fps
    task automatic test_endless_loop();
        program_regs(LE_ENDLESS, 8'd0, 16'h4002, rand48(), rand48(), rand48(),
                     rand48(), rand48());
        send_record(OP_INIT, 32'h0001_0000, 32'h0003_0000, 32'h1234_5678, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h0003_0000, 32'h0003_0000, 32'h0, 32'h0001_0000,
                    32'h0000_8000);
        send_record(OP_ADVANCE, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0001_0000,
                    32'h0005_0000);
        send_record(OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_record(OP_ADVANCE, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h0000_7FFF, 32'h0001_0000, 32'hFFFF_0000,
                    32'hFFFF_FFFF, 32'h0000_0001);
        send_record(OP_ADVANCE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_record(OP_ADVANCE, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'hFFFF_FFFF);
    endtask

    // limited lifetime: expiry on the limit, just below, init with a frame rate
    task automatic test_limited_life();
        program_regs(17'd10, 8'd24, 16'hC80A, rand48(), rand48(), rand48(),
                     rand48(), rand48());
        send_record(OP_INIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h0009_0000, 32'h0, 32'h0001_0000, 32'h0002_0000,
                    32'h0001_0000);
        send_record(OP_ADVANCE, 32'h0009_0000, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        send_record(OP_ADVANCE, 32'h0005_0000, 32'h0, 32'h0, 32'hFFFF_8000,
                    32'h0000_4000);
        send_record(OP_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h0, 32'h0, 32'h7FFF_0000, 32'h7FFF_FFFF,
                    32'h0008_0000);
    endtask

    // negative limits other than endless, reversed frame range, top frame rate
    task automatic test_negative_limit();
        program_regs(17'h1FFFE, 8'd255, 16'h10F0, rand48(), rand48(), rand48(),
                     rand48(), rand48());
        send_record(OP_INIT, 32'h0, 32'h5555_5555, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        program_regs(17'h10000, 8'd1, 16'hFF00, rand48(), rand48(), rand48(),
                     rand48(), rand48());
        send_record(OP_INIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    endtask

    // widest limit, all-ones frame range and keys; then a zero limit
    task automatic test_extreme_regs();
        program_regs(17'hFFFF, 8'd255, 16'hFFFF, '1, '1, '1, '1, '1);
        send_record(OP_INIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h7FFF_8000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        program_regs(17'd0, 8'd0, 16'h0000, '0, '0, '0, '0, '0);
        send_record(OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    endtask

    // random settings, each with a burst of mostly well-formed records
    task automatic test_random_records();
        int          phase;
        int          n;
        int          p;
        logic [16:0] le;
        logic [31:0] span;
        logic [31:0] age;
        logic [31:0] dt;
        logic [31:0] rate;
        longint      lim;
        op_t         op;
        for (phase = 0; phase < 6; phase++)
        begin
            p = $urandom_range(0, 9);
            if (p < 4)
                le = LE_ENDLESS;
            else if (p < 8)
                le = 17'($urandom_range(1, 30));
            else if (p == 8)
                le = 17'($urandom_range(0, 65535));
            else
                le = 17'($urandom);
            program_regs(le, 8'($urandom), 16'($urandom), rand48(), rand48(), rand48(),
                         rand48(), rand48());
            no_idle = (phase % 3 == 1);
            for (n = 0; n < 92; n++)
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    // noise: every bit free
                    op = op_t'($urandom_range(0, 1));
                    send_record(op, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
                else
                begin
                    op   = ($urandom_range(0, 9) == 0) ? OP_INIT : OP_ADVANCE;
                    lim  = (life_cfg >= 0) ? (longint'(life_cfg) << 16) : 0;
                    span = ($urandom_range(0, 2) == 0) ? $urandom
                         : 32'($urandom_range(0, 40)) << 16 | 32'($urandom_range(0, 65535));
                    if (life_cfg == LE_ENDLESS)
                        age = ($urandom_range(0, 4) == 0) ? span : $urandom_range(0, span);
                    else
                        age = $urandom_range(0, 32'(lim));
                    dt   = $urandom_range(0, 32'h0002_0000);
                    rate = $urandom_range(0, 1) ? $urandom : 32'(int'($urandom_range(0,
                           32'h0004_0000)) - 32'h0002_0000);
                    send_record(op, age, span, $urandom, rate, dt);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, in-order check, watchdog
    // ------------------------------------------------------------------------
    initial
    begin : ready_driver
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    // values at the falling edge are what the next rising edge will take
    initial
    begin : result_checker
        res_t want;
        forever
        begin
            @(negedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_records.size() == 0)
                begin
                    $error("result transaction with nothing pending");
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_records.pop_front();
                    if (res_ch.new_age !== want.new_age)
                    begin
                        $error("new_age expected %h got %h", want.new_age, res_ch.new_age);
                        failed = 1'b1;
                    end
                    if (res_ch.new_anim_span !== want.new_anim_span)
                    begin
                        $error("new_anim_span expected %h got %h", want.new_anim_span,
                               res_ch.new_anim_span);
                        failed = 1'b1;
                    end
                    if (res_ch.new_height !== want.new_height)
                    begin
                        $error("new_height expected %h got %h", want.new_height,
                               res_ch.new_height);
                        failed = 1'b1;
                    end
                    if (res_ch.frame_index !== want.frame_index)
                    begin
                        $error("frame_index expected %h got %h", want.frame_index,
                               res_ch.frame_index);
                        failed = 1'b1;
                    end
                    if (res_ch.particle_size !== want.particle_size)
                    begin
                        $error("particle_size expected %h got %h", want.particle_size,
                               res_ch.particle_size);
                        failed = 1'b1;
                    end
                    if (res_ch.red_level !== want.red_level)
                    begin
                        $error("red_level expected %h got %h", want.red_level,
                               res_ch.red_level);
                        failed = 1'b1;
                    end
                    if (res_ch.green_level !== want.green_level)
                    begin
                        $error("green_level expected %h got %h", want.green_level,
                               res_ch.green_level);
                        failed = 1'b1;
                    end
                    if (res_ch.blue_level !== want.blue_level)
                    begin
                        $error("blue_level expected %h got %h", want.blue_level,
                               res_ch.blue_level);
                        failed = 1'b1;
                    end
                    if (res_ch.opacity !== want.opacity)
                    begin
                        $error("opacity expected %h got %h", want.opacity, res_ch.opacity);
                        failed = 1'b1;
                    end
                    if (res_ch.expired !== want.expired)
                    begin
                        $error("expired expected %b got %b", want.expired, res_ch.expired);
                        failed = 1'b1;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        item_ch.valid     = 1'b0;
        item_ch.operation = 1'b0;
        item_ch.age       = '0;
        item_ch.anim_span = '0;
        item_ch.height    = '0;
        item_ch.rise_rate = '0;
        item_ch.time_step = '0;
        // register mirror starts at the reset values
        life_cfg    = LE_ENDLESS;
        fps_cfg     = '0;
        frames_cfg  = '0;
        size_cfg    = '0;
        alpha_cfg   = '0;
        color_s_cfg = '0;
        color_m_cfg = '0;
        color_e_cfg = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two records on the reset settings before any register write
        send_record(OP_INIT, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_record(OP_ADVANCE, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000,
                    32'h0001_0000);

        test_endless_loop();
        test_limited_life();
        test_negative_limit();
        test_extreme_regs();
        test_random_records();

        wait_idle();
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
